>>> design/bde_pkg.sv
// Shared types and constants for the battery discharge emulator.
// Used by bde_serial_alu and battery_discharge_emulator; depends on nothing.
`default_nettype none

package bde_pkg;

    // field widths
    localparam int OP_W       = 2;
    localparam int DELTA_W    = 16;
    localparam int RS_W       = 2;
    localparam int VOLT_W     = 16;
    localparam int CURRENT_W  = 21;
    localparam int DRAWN_W    = 42;
    localparam int NOMINAL_W  = 20;
    localparam int RET_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;

    localparam int OUT_FIELDS_W = RS_W + VOLT_W + CURRENT_W + DRAWN_W;
    localparam int M_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CHARGE_BITS_DEF = 42;

    // step counter of the serial unit covers a datapath of up to 127 bits
    localparam int STEP_W = 7;

    // dividend of the current division: |I| * delta + delta / 2 < 2^38
    localparam int CUR_DIV_BITS = CURRENT_W + DELTA_W + 1;

    // available capacity in mA*ms is nominal * retention * 360
    localparam logic [8:0] MAH_SCALE       = 9'd360;
    localparam int         MAH_SCALE_STEPS = 9;

    // defaults and fallbacks
    localparam logic [NOMINAL_W-1:0]        NOMINAL_DEF     = 20'd300000;
    localparam logic [RET_W-1:0]            RET_DEF         = 14'd10000;
    localparam logic [RET_W-1:0]            RET_MAX         = 14'd10000;
    localparam logic [CURRENT_W-1:0]        CURRENT_MAG_DEF = 21'd30000;
    localparam logic signed [CURRENT_W-1:0] CURRENT_DEF     = -21'sd30000;
    localparam logic [VOLT_W-1:0]           START_V_DEF     = 16'd12800;
    localparam logic [VOLT_W-1:0]           END_V_DEF       = 16'd10800;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETENTION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_V   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_V     = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_ABORT = 2'd2
    } opcode_t;

    typedef enum logic [RS_W-1:0] {
        RS_IDLE      = 2'd0,
        RS_RUNNING   = 2'd1,
        RS_COMPLETED = 2'd2,
        RS_ABORTED   = 2'd3
    } run_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AV_MUL1,
        ST_AV_MUL2,
        ST_AV_CHK,
        ST_REQ_MUL,
        ST_ADD,
        ST_CUR_DIV,
        ST_V_MUL,
        ST_V_DIV,
        ST_WRITE
    } seq_state_t;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic              start;
        alu_op_t           op;
        logic [STEP_W-1:0] steps;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

endpackage

`default_nettype wire

>>> design/battery_discharge_emulator.sv
// Battery discharge emulator top level: command sequencer, settings, result word.
// Depends on bde_pkg and bde_serial_alu.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | s_tuser: opcode; s_tdata: delta_ms
//  m_*     | out       | m_tvalid/m_tready  | m_tdata: run_state, voltage, current, charge
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Start, abort, idle ticks and zero-length ticks go from idle straight to the result write.
// A running tick walks one serial multiply/divide unit through up to four multiplies
// and two divides, and it stops early once the battery is drained.
// Reset is asynchronous; settings return to their defaults and the test to idle.
// The result register frees the sequencer: a new word is taken while the last result
// waits, and the sequencer holds in its final state until the result register is free.
`default_nettype none

module battery_discharge_emulator
    import bde_pkg::*;
#(
    parameter int CHARGE_BITS = CHARGE_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [DELTA_W-1:0]    s_tdata,   // [15:0] delta_ms
    input  wire logic [OP_W-1:0]       s_tuser,   // [1:0] opcode

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [1:0] run_state, [17:2] voltage_mv,
                                                  // [38:18] current_ma, [80:39] drawn_charge

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CB = CHARGE_BITS;
    localparam int DW = CHARGE_BITS + VOLT_W;

    localparam logic [CB-1:0] CHARGE_MAX     = {CB{1'b1}};
    localparam logic [DW-1:0] CHARGE_MAX_EXT = {{(DW-CB){1'b0}}, CHARGE_MAX};

    localparam logic [STEP_W-1:0] AV1_STEPS = STEP_W'(RET_W);
    localparam logic [STEP_W-1:0] AV2_STEPS = STEP_W'(MAH_SCALE_STEPS);
    localparam logic [STEP_W-1:0] REQ_STEPS = STEP_W'(DELTA_W);
    localparam logic [STEP_W-1:0] CUR_STEPS = STEP_W'(CUR_DIV_BITS);
    localparam logic [STEP_W-1:0] VM_STEPS  = STEP_W'(VOLT_W);
    localparam logic [STEP_W-1:0] VD_STEPS  = STEP_W'(DW);

    // sequencer and test state
    seq_state_t                   state_reg, state_next;
    logic                         alu_run_reg, alu_run_next;
    run_state_t                   test_reg, test_next;
    logic [CB-1:0]                charge_reg, charge_next;
    logic [VOLT_W-1:0]            voltage_reg, voltage_next;
    logic [CURRENT_W-1:0]         current_reg, current_next;

    // settings
    logic [NOMINAL_W-1:0]         nom_reg, nom_next;
    logic [RET_W-1:0]             ret_reg, ret_next;
    logic [CURRENT_W-1:0]         icfg_reg, icfg_next;
    logic [VOLT_W-1:0]            sv_reg, sv_next;
    logic [VOLT_W-1:0]            ev_reg, ev_next;

    // working registers
    logic [DELTA_W-1:0]           delta_reg, delta_next;
    logic [DW-1:0]                tmp_reg, tmp_next;
    logic [CB-1:0]                avail_reg, avail_next;
    logic [CB-1:0]                left_reg, left_next;
    logic [CB-1:0]                act_reg, act_next;

    // result register
    logic                         m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]         m_tdata_reg, m_tdata_next;

    alu_cmd_t                     alu_cmd;
    alu_stat_t                    alu_stat;
    logic [DW-1:0]                alu_a;
    logic [CB-1:0]                alu_b;
    logic [DW-1:0]                alu_result;
    logic                         alu_state;

    logic [NOMINAL_W-1:0]         eff_nom;
    logic [CURRENT_W-1:0]         eff_mag;
    logic [CURRENT_W-1:0]         start_cur;
    logic                         volt_ok;
    logic [VOLT_W-1:0]            eff_sv;
    logic [VOLT_W-1:0]            eff_ev;
    logic [VOLT_W-1:0]            span;
    logic [CUR_DIV_BITS-1:0]      cur_dividend;
    logic [DW-1:0]                charge_ext;

    bde_serial_alu #(
        .DATA_BITS    (DW),
        .DIVISOR_BITS (CB)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (alu_cmd),
        .op_a   (alu_a),
        .op_b   (alu_b),
        .result (alu_result),
        .stat   (alu_stat)
    );

    // effective settings
    assign eff_nom      = (nom_reg == '0) ? NOMINAL_DEF : nom_reg;
    assign eff_mag      = icfg_reg[CURRENT_W-1] ? (~icfg_reg + 1'b1) : CURRENT_MAG_DEF;
    assign start_cur    = icfg_reg[CURRENT_W-1] ? icfg_reg : CURRENT_DEF;
    assign volt_ok      = (sv_reg > ev_reg);
    assign eff_sv       = volt_ok ? sv_reg : START_V_DEF;
    assign eff_ev       = volt_ok ? ev_reg : END_V_DEF;
    assign span         = eff_sv - eff_ev;
    // act never exceeds |I| * delta, so it fits the dividend width
    assign cur_dividend = CUR_DIV_BITS'(act_reg) + CUR_DIV_BITS'(delta_reg[DELTA_W-1:1]);
    assign charge_ext   = DW'(charge_reg);

    always_comb
    begin
        state_next    = state_reg;
        alu_run_next  = alu_run_reg;
        test_next     = test_reg;
        charge_next   = charge_reg;
        voltage_next  = voltage_reg;
        current_next  = current_reg;
        nom_next      = nom_reg;
        ret_next      = ret_reg;
        icfg_next     = icfg_reg;
        sv_next       = sv_reg;
        ev_next       = ev_reg;
        delta_next    = delta_reg;
        tmp_next      = tmp_reg;
        avail_next    = avail_reg;
        left_next     = left_reg;
        act_next      = act_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;

        alu_cmd   = '0;
        alu_a     = '0;
        alu_b     = '0;
        alu_state = 1'b0;
        s_tready  = 1'b0;
        cfg_ready = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    delta_next = s_tdata;
                    state_next = ST_WRITE;
                    case (opcode_t'(s_tuser))
                        OP_TICK:
                        begin
                            if (test_reg == RS_RUNNING && s_tdata != '0)
                                state_next = ST_AV_MUL1;
                        end
                        OP_START:
                        begin
                            charge_next  = '0;
                            voltage_next = eff_sv;
                            current_next = start_cur;
                            test_next    = RS_RUNNING;
                        end
                        OP_ABORT:
                        begin
                            if (test_reg == RS_RUNNING)
                            begin
                                test_next    = RS_ABORTED;
                                current_next = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_AV_MUL1:
            begin
                alu_state     = 1'b1;
                alu_cmd.op    = ALU_MUL;
                alu_cmd.steps = AV1_STEPS;
                alu_a         = DW'(eff_nom);
                alu_b         = CB'(ret_reg);
                if (alu_stat.done)
                begin
                    tmp_next   = alu_result;
                    state_next = ST_AV_MUL2;
                end
            end

            ST_AV_MUL2:
            begin
                alu_state     = 1'b1;
                alu_cmd.op    = ALU_MUL;
                alu_cmd.steps = AV2_STEPS;
                alu_a         = tmp_reg;
                alu_b         = CB'(MAH_SCALE);
                if (alu_stat.done)
                begin
                    // saturate to the charge width
                    avail_next = (alu_result > CHARGE_MAX_EXT) ? CHARGE_MAX
                                                               : alu_result[CB-1:0];
                    state_next = ST_AV_CHK;
                end
            end

            ST_AV_CHK:
            begin
                if (avail_reg == '0)
                begin
                    voltage_next = eff_ev;
                    current_next = '0;
                    test_next    = RS_COMPLETED;
                    state_next   = ST_WRITE;
                end
                else
                begin
                    left_next  = (charge_reg < avail_reg) ? (avail_reg - charge_reg) : '0;
                    state_next = ST_REQ_MUL;
                end
            end

            ST_REQ_MUL:
            begin
                alu_state     = 1'b1;
                alu_cmd.op    = ALU_MUL;
                alu_cmd.steps = REQ_STEPS;
                alu_a         = DW'(eff_mag);
                alu_b         = CB'(delta_reg);
                if (alu_stat.done)
                begin
                    act_next   = (alu_result < {{(DW-CB){1'b0}}, left_reg})
                                 ? alu_result[CB-1:0] : left_reg;
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                charge_next = charge_reg + act_reg;
                state_next  = ST_CUR_DIV;
            end

            ST_CUR_DIV:
            begin
                alu_state     = 1'b1;
                alu_cmd.op    = ALU_DIV;
                alu_cmd.steps = CUR_STEPS;
                alu_a         = {cur_dividend, {(DW-CUR_DIV_BITS){1'b0}}};
                alu_b         = CB'(delta_reg);
                if (alu_stat.done)
                begin
                    current_next = CURRENT_W'(0) - alu_result[CURRENT_W-1:0];
                    if (charge_reg >= avail_reg)
                    begin
                        voltage_next = eff_ev;
                        test_next    = RS_COMPLETED;
                        state_next   = ST_WRITE;
                    end
                    else
                        state_next = ST_V_MUL;
                end
            end

            ST_V_MUL:
            begin
                alu_state     = 1'b1;
                alu_cmd.op    = ALU_MUL;
                alu_cmd.steps = VM_STEPS;
                alu_a         = charge_ext;
                alu_b         = CB'(span);
                if (alu_stat.done)
                begin
                    // round to nearest, halves up
                    tmp_next   = alu_result + DW'(avail_reg[CB-1:1]);
                    state_next = ST_V_DIV;
                end
            end

            ST_V_DIV:
            begin
                alu_state     = 1'b1;
                alu_cmd.op    = ALU_DIV;
                alu_cmd.steps = VD_STEPS;
                alu_a         = tmp_reg;
                alu_b         = avail_reg;
                if (alu_stat.done)
                begin
                    voltage_next = eff_sv - alu_result[VOLT_W-1:0];
                    state_next   = ST_WRITE;
                end
            end

            ST_WRITE:
            begin
                // hold until the result register is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = M_TDATA_W'({charge_ext[DRAWN_W-1:0], current_reg,
                                                voltage_reg, test_reg});
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // launch the serial unit once per arithmetic state, advance on done
        if (alu_state)
        begin
            if (!alu_run_reg)
            begin
                alu_cmd.start = 1'b1;
                alu_run_next  = 1'b1;
            end
            else if (alu_stat.done)
                alu_run_next = 1'b0;
        end

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_NOMINAL:   nom_next = cfg_data[NOMINAL_W-1:0];
                CFG_RETENTION:
                begin
                    if (test_reg != RS_RUNNING && cfg_data[RET_W-1:0] <= RET_MAX)
                        ret_next = cfg_data[RET_W-1:0];
                end
                CFG_CURRENT:   icfg_next = cfg_data;
                CFG_START_V:   sv_next   = cfg_data[VOLT_W-1:0];
                CFG_END_V:     ev_next   = cfg_data[VOLT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            alu_run_reg  <= 1'b0;
            test_reg     <= RS_IDLE;
            charge_reg   <= '0;
            voltage_reg  <= '0;
            current_reg  <= '0;
            nom_reg      <= NOMINAL_DEF;
            ret_reg      <= RET_DEF;
            icfg_reg     <= CURRENT_DEF;
            sv_reg       <= START_V_DEF;
            ev_reg       <= END_V_DEF;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            alu_run_reg  <= alu_run_next;
            test_reg     <= test_next;
            charge_reg   <= charge_next;
            voltage_reg  <= voltage_next;
            current_reg  <= current_next;
            nom_reg      <= nom_next;
            ret_reg      <= ret_next;
            icfg_reg     <= icfg_next;
            sv_reg       <= sv_next;
            ev_reg       <= ev_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg   <= delta_next;
        tmp_reg     <= tmp_next;
        avail_reg   <= avail_next;
        left_reg    <= left_next;
        act_reg     <= act_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // an accepted word always leaves the idle state
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after taking a word");

    // the serial unit reports done only for a launched operation
    a_done_when_run: assert property (@(posedge clk) disable iff (!rst_n)
        alu_stat.done |-> alu_run_reg)
        else $error("serial unit done without a launched operation");

    // the voltage path is entered only with charge still below capacity
    a_vmul_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_V_MUL) |-> (charge_reg < avail_reg))
        else $error("voltage interpolation with battery drained");

    // tick current quotient never exceeds the current field
    a_cur_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CUR_DIV && alu_stat.done) |->
        (alu_result[DW-1:CURRENT_W] == '0))
        else $error("tick current quotient overflow");

endmodule

`default_nettype wire

>>> design/bde_serial_alu.sv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
// Depends on bde_pkg for the command and status structs.
`default_nettype none

module bde_serial_alu
    import bde_pkg::*;
#(
    parameter int DATA_BITS    = CHARGE_BITS_DEF + VOLT_W,
    parameter int DIVISOR_BITS = CHARGE_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire alu_cmd_t                cmd,
    input  wire logic [DATA_BITS-1:0]    op_a,    // multiplicand or left-aligned dividend
    input  wire logic [DIVISOR_BITS-1:0] op_b,    // multiplier or divisor
    output logic [DATA_BITS-1:0]         result,  // product, or quotient in the low bits
    output alu_stat_t                    stat
);

    logic [DATA_BITS-1:0]    acc_reg, acc_next;
    logic [DATA_BITS-1:0]    a_reg, a_next;
    logic [DIVISOR_BITS-1:0] b_reg, b_next;
    logic [DIVISOR_BITS:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]       cnt_reg, cnt_next;
    alu_op_t                 op_reg, op_next;
    logic                    done_reg, done_next;

    logic [DIVISOR_BITS:0]   rem_sh;
    logic [DIVISOR_BITS+1:0] diff;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        done_next = 1'b0;

        rem_sh = {rem_reg[DIVISOR_BITS-1:0], acc_reg[DATA_BITS-1]};
        diff   = {1'b0, rem_sh} - {2'b00, b_reg};

        if (cmd.start)
        begin
            op_next  = cmd.op;
            cnt_next = cmd.steps;
            a_next   = op_a;
            b_next   = op_b;
            rem_next = '0;
            acc_next = (cmd.op == ALU_DIV) ? op_a : '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == STEP_W'(1));
            if (op_reg == ALU_MUL)
            begin
                if (b_reg[0])
                    acc_next = acc_reg + a_reg;
                a_next = {a_reg[DATA_BITS-2:0], 1'b0};
                b_next = {1'b0, b_reg[DIVISOR_BITS-1:1]};
            end
            else
            begin
                // restore when the trial subtract borrows
                if (diff[DIVISOR_BITS+1])
                begin
                    rem_next = rem_sh;
                    acc_next = {acc_reg[DATA_BITS-2:0], 1'b0};
                end
                else
                begin
                    rem_next = diff[DIVISOR_BITS:0];
                    acc_next = {acc_reg[DATA_BITS-2:0], 1'b1};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            op_reg   <= ALU_MUL;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    assign result    = acc_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

endmodule

`default_nettype wire

>>> sim/tb_battery_discharge_emulator.sv
// Testbench for battery_discharge_emulator: directed command table, then random test phases,
// every result word checked against a cycle-free model of the discharge test or a typed table entry.
// Depends on bde_pkg and the battery_discharge_emulator RTL.
`timescale 1ns / 100ps

module tb_battery_discharge_emulator;
    import bde_pkg::*;

    localparam int RANDOM_WORDS     = 1650;
    localparam int SINK_HOLD_CYCLES = 500;
    localparam int TAIL_CYCLES      = 250;

    localparam logic [OP_W-1:0]      OP_UNUSED     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
    localparam longint unsigned      CHARGE_LIMIT  = (64'd1 << DRAWN_W) - 1;

    typedef struct packed {
        run_state_t           rs;
        logic [VOLT_W-1:0]    volt;
        logic [CURRENT_W-1:0] cur;
        logic [DRAWN_W-1:0]   drawn;
    } sample_t;

    typedef enum logic {
        ROW_WORD,
        ROW_SETTING
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [OP_W-1:0]       op;
        logic [CFG_DATA_W-1:0] arg;
        logic                  typed;
        sample_t               want;
    } row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [DELTA_W-1:0]    s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // model copy of the settings and of the running test
    logic [NOMINAL_W-1:0]  set_nominal;
    logic [RET_W-1:0]      set_retention;
    logic [CURRENT_W-1:0]  set_current;
    logic [VOLT_W-1:0]     set_vstart;
    logic [VOLT_W-1:0]     set_vend;
    run_state_t            bat_state;
    longint unsigned       bat_drawn;
    logic [VOLT_W-1:0]     bat_volt;
    logic [CURRENT_W-1:0]  bat_cur;

    sample_t expected_samples [$];
    int      mismatches;
    int      burst_left;
    bit      hold_sink;

    battery_discharge_emulator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // advance the test by one command and return the sample it reports
    function automatic sample_t battery_step(input logic [OP_W-1:0] op,
                                             input logic [DELTA_W-1:0] dms);
        longint unsigned mag;
        longint unsigned nom_eff;
        longint unsigned avail;
        longint unsigned req;
        longint unsigned room;
        longint unsigned taken;
        longint unsigned q;
        longint unsigned span;
        longint unsigned drop;
        logic [VOLT_W-1:0] v_hi;
        logic [VOLT_W-1:0] v_lo;
        sample_t s;
        mag     = set_current[CURRENT_W-1] ? (64'h200000 - set_current) : CURRENT_MAG_DEF;
        nom_eff = (set_nominal == 0) ? NOMINAL_DEF : set_nominal;
        v_hi    = (set_vstart > set_vend) ? set_vstart : START_V_DEF;
        v_lo    = (set_vstart > set_vend) ? set_vend : END_V_DEF;
        case (op)
            OP_TICK:
            begin
                if (bat_state == RS_RUNNING && dms != 0)
                begin
                    avail = nom_eff * set_retention * MAH_SCALE;
                    if (avail > CHARGE_LIMIT)
                        avail = CHARGE_LIMIT;
                    if (avail == 0)
                    begin
                        bat_volt  = v_lo;
                        bat_cur   = '0;
                        bat_state = RS_COMPLETED;
                    end
                    else
                    begin
                        req       = mag * dms;
                        room      = (bat_drawn < avail) ? avail - bat_drawn : 0;
                        taken     = (req < room) ? req : room;
                        bat_drawn = bat_drawn + taken;
                        q         = (taken + dms / 2) / dms;
                        bat_cur   = -q[CURRENT_W-1:0];
                        if (bat_drawn >= avail)
                        begin
                            bat_volt  = v_lo;
                            bat_state = RS_COMPLETED;
                        end
                        else
                        begin
                            span     = v_hi - v_lo;
                            drop     = (span * bat_drawn + avail / 2) / avail;
                            bat_volt = v_hi - drop[VOLT_W-1:0];
                        end
                    end
                end
            end
            OP_START:
            begin
                bat_drawn = 0;
                bat_volt  = v_hi;
                bat_cur   = -mag[CURRENT_W-1:0];
                bat_state = RS_RUNNING;
            end
            OP_ABORT:
            begin
                if (bat_state == RS_RUNNING)
                begin
                    bat_state = RS_ABORTED;
                    bat_cur   = '0;
                end
            end
            default: ;
        endcase
        s.rs    = bat_state;
        s.volt  = bat_volt;
        s.cur   = bat_cur;
        s.drawn = bat_drawn[DRAWN_W-1:0];
        return s;
    endfunction

    function automatic row_t word_row(input logic [OP_W-1:0] op, input logic [DELTA_W-1:0] dms);
        row_t r;
        r      = '0;
        r.kind = ROW_WORD;
        r.op   = op;
        r.arg  = dms;
        return r;
    endfunction

    function automatic row_t typed_row(input logic [OP_W-1:0] op, input logic [DELTA_W-1:0] dms,
                                       input run_state_t rs, input logic [VOLT_W-1:0] volt,
                                       input logic [CURRENT_W-1:0] cur,
                                       input logic [DRAWN_W-1:0] drawn);
        row_t r;
        r            = word_row(op, dms);
        r.typed      = 1'b1;
        r.want.rs    = rs;
        r.want.volt  = volt;
        r.want.cur   = cur;
        r.want.drawn = drawn;
        return r;
    endfunction

    function automatic row_t setting_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        row_t r;
        r      = '0;
        r.kind = ROW_SETTING;
        r.idx  = idx;
        r.arg  = data;
        return r;
    endfunction

    // offer one word in bursts with random gaps; log its expected sample on acceptance
    task automatic offer_word(input logic [OP_W-1:0] op, input logic [DELTA_W-1:0] dms,
                              input logic typed, input sample_t typed_want);
        int gap;
        int pick;
        sample_t got;
        if (burst_left == 0)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                gap = 0;
            else if (pick < 9)
                gap = $urandom_range(1, 6);
            else
                gap = $urandom_range(15, 40);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= dms;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        burst_left--;
        got = battery_step(op, dms);
        expected_samples.push_back(typed ? typed_want : got);
    endtask

    // leave cfg_valid high; the caller drops it after the last write of a batch
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        case (idx)
            CFG_NOMINAL:   set_nominal = data[NOMINAL_W-1:0];
            CFG_RETENTION:
            begin
                if (bat_state != RS_RUNNING && data[RET_W-1:0] <= RET_MAX)
                    set_retention = data[RET_W-1:0];
            end
            CFG_CURRENT:   set_current = data;
            CFG_START_V:   set_vstart = data[VOLT_W-1:0];
            CFG_END_V:     set_vend = data[VOLT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain_samples();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_watch
        sample_t want;
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t ns: unexpected result word, expected none, actual %0h",
                         $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = expected_samples.pop_front();
                check_field("run_state", want.rs, m_tdata[1:0]);
                check_field("voltage_mv", want.volt, m_tdata[17:2]);
                check_field("current_ma", want.cur, m_tdata[38:18]);
                check_field("drawn_charge", want.drawn, m_tdata[80:39]);
            end
        end
    end

    // receiver: stall patterns drawn anew at random intervals, plus one long hold
    initial
    begin : result_sink
        int mode;
        int mode_left;
        int cyc;
        logic [15:0] pat;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        cyc       = 0;
        pat       = 16'hFFFF;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                hold_sink = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
                pat       = 16'($urandom) | 16'h1;
            end
            mode_left--;
            cyc++;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 9) < 7);
                2:       m_tready <= pat[cyc % 16];
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        row_t dir_rows [$];
        row_t r;
        logic [OP_W-1:0] op;
        logic [DELTA_W-1:0] dms;
        logic [CFG_DATA_W-1:0] sdata;
        logic [VOLT_W-1:0] vs;
        logic [VOLT_W-1:0] ve;
        int counted;
        int in_phase;
        int phase_len;
        int phase;
        int dmode;
        int pick;
        bit was_running;

        clk       = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        hold_sink = 1'b0;
        mismatches = 0;
        burst_left = 0;

        set_nominal   = NOMINAL_DEF;
        set_retention = RET_DEF;
        set_current   = CURRENT_DEF;
        set_vstart    = START_V_DEF;
        set_vend      = END_V_DEF;
        bat_state     = RS_IDLE;
        bat_drawn     = 0;
        bat_volt      = '0;
        bat_cur       = '0;

        // defaults: idle commands, a test run, abort and restart
        dir_rows.push_back(typed_row(OP_TICK, 16'd100, RS_IDLE, '0, '0, '0));
        dir_rows.push_back(typed_row(OP_ABORT, 16'd0, RS_IDLE, '0, '0, '0));
        dir_rows.push_back(typed_row(OP_UNUSED, 16'hFFFF, RS_IDLE, '0, '0, '0));
        dir_rows.push_back(typed_row(OP_START, 16'd0, RS_RUNNING, START_V_DEF, CURRENT_DEF, '0));
        dir_rows.push_back(typed_row(OP_TICK, 16'd0, RS_RUNNING, START_V_DEF, CURRENT_DEF, '0));
        dir_rows.push_back(word_row(OP_TICK, 16'hFFFF));
        dir_rows.push_back(word_row(OP_UNUSED, 16'd3));
        dir_rows.push_back(word_row(OP_ABORT, 16'd0));
        dir_rows.push_back(word_row(OP_TICK, 16'd5));
        dir_rows.push_back(word_row(OP_ABORT, 16'd0));
        dir_rows.push_back(typed_row(OP_START, 16'd0, RS_RUNNING, START_V_DEF, CURRENT_DEF, '0));
        // retention is locked while running; out of range is dropped
        dir_rows.push_back(setting_row(CFG_RETENTION, 21'd0));
        dir_rows.push_back(setting_row(CFG_RETENTION, 21'd10001));
        dir_rows.push_back(setting_row(CFG_NOMINAL, 21'd1));
        dir_rows.push_back(setting_row(CFG_CURRENT, -21'sd1000000));
        dir_rows.push_back(setting_row(CFG_START_V, 21'd65535));
        dir_rows.push_back(setting_row(CFG_END_V, 21'd0));
        // tiny capacity drains within two ticks
        dir_rows.push_back(word_row(OP_TICK, 16'd1));
        dir_rows.push_back(word_row(OP_TICK, 16'd3));
        dir_rows.push_back(word_row(OP_TICK, 16'd10));
        dir_rows.push_back(word_row(OP_ABORT, 16'd0));
        dir_rows.push_back(typed_row(OP_START, 16'd0, RS_RUNNING, 16'd65535, -21'sd1000000, '0));
        dir_rows.push_back(typed_row(OP_ABORT, 16'd0, RS_ABORTED, 16'd65535, '0, '0));
        // zero retention, fallback current and voltages
        dir_rows.push_back(setting_row(CFG_RETENTION, 21'd0));
        dir_rows.push_back(setting_row(CFG_CURRENT, 21'd0));
        dir_rows.push_back(setting_row(CFG_START_V, 21'd100));
        dir_rows.push_back(setting_row(CFG_END_V, 21'd100));
        dir_rows.push_back(setting_row(CFG_NOMINAL, 21'd0));
        dir_rows.push_back(typed_row(OP_START, 16'd0, RS_RUNNING, START_V_DEF, CURRENT_DEF, '0));
        dir_rows.push_back(typed_row(OP_TICK, 16'd0, RS_RUNNING, START_V_DEF, CURRENT_DEF, '0));
        dir_rows.push_back(typed_row(OP_TICK, 16'd7, RS_COMPLETED, END_V_DEF, '0, '0));
        // largest nominal and current, smallest voltage span, unused indexes
        dir_rows.push_back(setting_row(CFG_RETENTION, 21'd10000));
        dir_rows.push_back(setting_row(CFG_CURRENT, 21'h100000));
        dir_rows.push_back(setting_row(CFG_NOMINAL, 21'hFFFFF));
        dir_rows.push_back(setting_row(CFG_START_V, 21'd1));
        dir_rows.push_back(setting_row(CFG_END_V, 21'd0));
        dir_rows.push_back(setting_row(CFG_UNUSED_LO, 21'h1FFFFF));
        dir_rows.push_back(setting_row(CFG_UNUSED_HI, 21'd0));
        dir_rows.push_back(typed_row(OP_START, 16'd0, RS_RUNNING, 16'd1, 21'h100000, '0));
        dir_rows.push_back(word_row(OP_TICK, 16'hFFFF));
        dir_rows.push_back(word_row(OP_TICK, 16'd1));
        dir_rows.push_back(word_row(OP_TICK, 16'd2));
        dir_rows.push_back(word_row(OP_UNUSED, 16'd0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            if (r.kind == ROW_SETTING)
            begin
                drain_samples();
                write_setting(r.idx, r.arg);
            end
            else
            begin
                cfg_valid <= 1'b0;
                offer_word(r.op, r.arg[DELTA_W-1:0], r.typed, r.want);
            end
        end

        counted = 0;
        phase   = 0;
        while (counted < RANDOM_WORDS)
        begin
            drain_samples();
            if ($urandom_range(0, 9) < 6)
            begin
                sdata = 21'($urandom);
                case ($urandom_range(0, 9))
                    0:          sdata[NOMINAL_W-1:0] = '0;
                    1:          sdata[NOMINAL_W-1:0] = 20'hFFFFF;
                    2:          sdata[NOMINAL_W-1:0] = 20'd1000000;
                    3, 4, 5, 6: sdata[NOMINAL_W-1:0] = 20'($urandom_range(1, 40));
                    7:          sdata[NOMINAL_W-1:0] = 20'($urandom_range(41, 2000));
                    default:    sdata[NOMINAL_W-1:0] = 20'($urandom);
                endcase
                write_setting(CFG_NOMINAL, sdata);
            end
            if ($urandom_range(0, 9) < 6)
            begin
                sdata = 21'($urandom);
                case ($urandom_range(0, 9))
                    0:       sdata[RET_W-1:0] = '0;
                    1:       sdata[RET_W-1:0] = RET_MAX;
                    2:       sdata[RET_W-1:0] = 14'($urandom_range(10001, 16383));
                    3:       sdata[RET_W-1:0] = 14'($urandom_range(1, 100));
                    default: sdata[RET_W-1:0] = 14'($urandom_range(1000, 10000));
                endcase
                write_setting(CFG_RETENTION, sdata);
            end
            if ($urandom_range(0, 9) < 6)
            begin
                case ($urandom_range(0, 9))
                    0:       sdata = '0;
                    1:       sdata = 21'h100000;
                    2:       sdata = -21'sd1000000;
                    3:       sdata = '1;
                    4:       sdata = {1'b0, 20'($urandom)};
                    default: sdata = -21'($urandom_range(1000, 200000));
                endcase
                write_setting(CFG_CURRENT, sdata);
            end
            if ($urandom_range(0, 9) < 6)
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        vs = 16'hFFFF;
                        ve = '0;
                    end
                    1:
                    begin
                        vs = 16'($urandom);
                        ve = vs;
                    end
                    2:
                    begin
                        ve = 16'($urandom_range(1, 65535));
                        vs = 16'($urandom_range(0, ve - 1));
                    end
                    default:
                    begin
                        vs = 16'($urandom_range(1000, 65535));
                        ve = 16'($urandom_range(0, vs - 1));
                    end
                endcase
                sdata = 21'($urandom);
                sdata[VOLT_W-1:0] = vs;
                write_setting(CFG_START_V, sdata);
                sdata = 21'($urandom);
                sdata[VOLT_W-1:0] = ve;
                write_setting(CFG_END_V, sdata);
            end
            if ($urandom_range(0, 9) == 0)
                write_setting(CFG_UNUSED_LO + 3'($urandom_range(0, 2)), 21'($urandom));
            cfg_valid <= 1'b0;

            // hold the receiver off while words keep coming, to back the block up
            if (phase == 2)
                hold_sink = 1'b1;

            dmode     = $urandom_range(0, 3);
            phase_len = $urandom_range(40, 110);
            in_phase  = 0;
            while (in_phase < phase_len)
            begin
                pick = $urandom_range(0, 99);
                case (dmode)
                    0:       dms = 16'($urandom_range(1, 20));
                    1:       dms = 16'($urandom_range(1, 500));
                    2:       dms = 16'($urandom);
                    default: dms = 16'($urandom_range(0, 3));
                endcase
                if (bat_state != RS_RUNNING && $urandom_range(0, 9) < 8)
                    op = OP_START;
                else if (pick < 4)
                    op = OP_ABORT;
                else if (pick < 7)
                    op = OP_START;
                else if (pick < 9)
                    op = OP_UNUSED;
                else if (pick < 11)
                begin
                    op  = OP_TICK;
                    dms = '0;
                end
                else if (pick < 15)
                begin
                    op  = OP_W'($urandom);
                    dms = 16'($urandom);
                end
                else
                    op = OP_TICK;
                was_running = (bat_state == RS_RUNNING);
                offer_word(op, dms, 1'b0, '0);
                if (was_running || op == OP_START)
                    in_phase++;
            end
            // stop the test now and then so retention can be rewritten
            if ($urandom_range(0, 1) == 0)
                offer_word(OP_ABORT, 16'($urandom), 1'b0, '0);
            counted += in_phase;
            phase++;
        end

        drain_samples();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
design/bde_pkg.sv
design/bde_serial_alu.sv
design/battery_discharge_emulator.sv
sim/tb_battery_discharge_emulator.sv
